@@ hw/rtl/bsa_pkg.sv @@
// Shared types, constants and the slot hash for the beacon slot avoidance block.
package bsa_pkg;

  localparam int ID_BYTES    = 8;
  localparam int N_SLOTS     = 16;
  localparam int SLOT_W      = 4;
  localparam int DELAY_W     = 13;
  localparam int QUEUE_DEPTH = 2;

  // slot length in ms
  localparam logic [DELAY_W-1:0] SLOT_MS = 13'd500;

  // Reciprocal constants for division by a constant: q = (x * M) >> S.
  // now_ms / 500 is done as (now_ms >> 2) / 125 on 30 bits.
  localparam logic [30:0] RECIP_125 = 31'd1099511628;
  localparam int          SHIFT_125 = 37;
  // random_word % 200 uses (random_word >> 3) / 25 on 29 bits.
  localparam logic [29:0] RECIP_25  = 30'd687194768;
  localparam int          SHIFT_25  = 34;
  // random_word % 300 uses (random_word >> 2) / 75 on 30 bits.
  localparam logic [30:0] RECIP_75  = 31'd1832519380;
  localparam int          SHIFT_75  = 37;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_BEACON = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_OUT
  } back_state_t;

  // one classified transaction waiting for the back end
  typedef struct packed {
    opcode_t           op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       now_ms;
    logic [31:0]       random_word;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  // h = h*31 + byte, mod 16. Since 31 == -1 mod 16 only the low nibble
  // of h matters: h = byte - h on 4 bits.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [63:0] id);
    logic [SLOT_W-1:0] h;
    h = '0;
    for (int k = 0; k < ID_BYTES; k++) begin
      h = id[8*k +: SLOT_W] - h;
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/bsa_front.sv @@
// Front end: accepts input transactions, hashes beacon ids and queues work.
module bsa_front import bsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_node_id,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_random_word,
  output queue_head_t head,
  input  logic        pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  queue_entry_t     new_entry;
  logic             push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));

  // classify; unused opcode is dropped here
  always_comb begin
    new_entry.op          = opcode_t'(in_opcode);
    new_entry.slot        = slot_of(in_node_id);
    new_entry.now_ms      = in_now_ms;
    new_entry.random_word = in_random_word;
  end

  assign push   = in_valid && in_ready && (opcode_t'(in_opcode) != OP_NONE);
  assign do_pop = pop && (count_r != '0);

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

@@ hw/rtl/bsa_back.sv @@
// Back end: busy-slot state, own slot, delay computation and result register.
module bsa_back import bsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  queue_head_t        head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DELAY_W-1:0] out_delay_ms
);

  back_state_t        state_r, state_nxt;
  logic [N_SLOTS-1:0] busy_r, busy_nxt;
  logic               ready_r, ready_nxt;
  logic [SLOT_W-1:0]  own_slot_r, own_slot_nxt;
  logic               out_valid_r, out_valid_nxt;

  // query operands and intermediate results (no reset needed)
  logic [SLOT_W-1:0]  cur_r;
  logic [4:0]         q25_r;
  logic [6:0]         q75_r;
  logic [8:0]         rnd_lo_r;
  logic [7:0]         rem200_r;
  logic [8:0]         rem300_r;
  logic               found_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [DELAY_W-1:0] out_delay_r;

  logic               load_ops;
  logic               load_rem;
  logic               load_out;
  logic               out_free;

  logic [60:0]        prod_now;
  logic [58:0]        prod_25;
  logic [60:0]        prod_75;
  logic [N_SLOTS-1:0] beacon_map;
  logic [4:0]         r25;
  logic [6:0]         r75;
  logic [N_SLOTS-1:0] avail;
  logic [N_SLOTS-1:0] rot;
  logic               found;
  logic [SLOT_W-1:0]  idx;
  logic [DELAY_W-1:0] result;

  assign out_free = !out_valid_r || out_ready;

  // reciprocal multiplies on the popped query
  always_comb begin
    prod_now = {31'b0, head.entry.now_ms[31:2]} * {30'b0, RECIP_125};
    prod_25  = {30'b0, head.entry.random_word[31:3]} * {29'b0, RECIP_25};
    prod_75  = {31'b0, head.entry.random_word[31:2]} * {30'b0, RECIP_75};
  end

  // beacon update with wrap when the frame fills
  always_comb begin
    beacon_map = busy_r | (N_SLOTS'(1) << head.entry.slot);
    if (beacon_map == '1) begin
      beacon_map = '0;
    end
  end

  // remainders: only the low bits of quotient and dividend are needed
  always_comb begin
    r25 = rnd_lo_r[7:3] - 5'(q25_r * 5'd25);
    r75 = rnd_lo_r[8:2] - 7'(q75_r * 7'd75);
  end

  // rotate free-slot map to start at the current slot, take first free
  always_comb begin
    avail = ~busy_r & ~(N_SLOTS'(1) << own_slot_r);
    for (int i = 0; i < N_SLOTS; i++) begin
      rot[i] = avail[SLOT_W'(cur_r + SLOT_W'(i))];
    end
    found = |rot;
    idx   = '0;
    for (int i = N_SLOTS - 1; i >= 0; i--) begin
      if (rot[i]) begin
        idx = SLOT_W'(i);
      end
    end
  end

  // final delay
  always_comb begin
    if (!ready_r || busy_r == '0) begin
      result = '0;
    end else if (found_r) begin
      result = DELAY_W'(DELAY_W'(idx_r) * SLOT_MS) + DELAY_W'(rem200_r);
    end else begin
      result = DELAY_W'(rem300_r);
    end
  end

  // sequencer: next state and control
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    ready_nxt     = ready_r;
    own_slot_nxt  = cfg_we ? slot_of(cfg_wdata) : own_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;
    load_ops      = 1'b0;
    load_rem      = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.entry.op)
            OP_INIT: begin
              busy_nxt  = '0;
              ready_nxt = 1'b1;
            end
            OP_BEACON: begin
              if (ready_r) begin
                busy_nxt = beacon_map;
              end
            end
            OP_QUERY: begin
              load_ops  = 1'b1;
              state_nxt = S_REM;
            end
            default: begin
            end
          endcase
        end
      end
      S_REM: begin
        load_rem  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      ready_r     <= 1'b0;
      own_slot_r  <= slot_of(64'd0);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      ready_r     <= ready_nxt;
      own_slot_r  <= own_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_ops) begin
      cur_r    <= prod_now[SHIFT_125 +: SLOT_W];
      q25_r    <= prod_25[SHIFT_25 +: 5];
      q75_r    <= prod_75[SHIFT_75 +: 7];
      rnd_lo_r <= head.entry.random_word[8:0];
    end
    if (load_rem) begin
      rem200_r <= {r25, rnd_lo_r[2:0]};
      rem300_r <= {r75, rnd_lo_r[1:0]};
      found_r  <= found;
      idx_r    <= idx;
    end
    if (load_out) begin
      out_delay_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_delay_ms = out_delay_r;

endmodule

@@ hw/rtl/beacon_slot_avoidance.sv @@
// Top level of the beacon slot avoidance scheduler for a 16-slot frame.
// Init and beacon transactions: retired one per cycle by the back end while it is idle.
// Query: queued, then the back-end sequencer runs its multiply, remainder/scan and
//   load steps (load waits for a free output); it starts no new query until done.
// A 2-entry queue lets the front accept while a result waits at the output.
// Reset (rst_n, synchronous, active low) clears busy map, ready flag, own slot,
//   queue and output valid; it takes effect at once with no clearing pass.
module beacon_slot_avoidance import bsa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [63:0]        in_node_id,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_random_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DELAY_W-1:0] out_delay_ms
);

  queue_head_t head;
  logic        pop;

  bsa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_node_id     (in_node_id),
    .in_now_ms      (in_now_ms),
    .in_random_word (in_random_word),
    .head           (head),
    .pop            (pop)
  );

  bsa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_delay_ms (out_delay_ms)
  );

endmodule
